// ===== rtl/core/mspi_pkg.sv =====
// Shared constants and defaults for the motor speed PI controller.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package mspi_pkg;

  // defaults for the top-level parameters
  localparam int SAMPLE_BITS_DEF        = 8;
  localparam int OUTPUT_LIMIT_VOLTS_DEF = 10;

  // fixed field widths
  localparam int GAIN_W   = 16;
  localparam int SPEED_W  = 17;  // Q.8 Hz, 0..76800
  localparam int ERROR_W  = 18;  // signed Q.8 Hz
  localparam int LEVEL_W  = 20;  // Q4.16 volts
  localparam int DUTY_W   = 7;
  localparam int ACC_W    = 36;  // Q.24 accumulator
  localparam int FRAC_SHIFT = 8; // Q.24 down to Q.16

  // full speed span in Q.8 Hz: 300 Hz times 256
  localparam int SPEED_SPAN_Q8 = 300 * 256;
  localparam int DUTY_MAX      = 127;

  // configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = GAIN_W;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_CURRENT  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_PREVIOUS = 1'd1;

  localparam logic [GAIN_W-1:0] GAIN_CURRENT_RESET  = 16'd1916;
  localparam logic [GAIN_W-1:0] GAIN_PREVIOUS_RESET = 16'd1894;

  // sample source tags
  localparam logic SRC_SETPOINT = 1'b0;
  localparam logic SRC_SPEED    = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/core/mspi_channels.sv =====
// Valid/ready channel interfaces for samples in and controller results out.
// Depends on mspi_pkg for field widths and defaults.
`default_nettype none

interface mspi_sample_if #(
  parameter int SAMPLE_BITS = mspi_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   source;

  modport src  (output valid, output sample, output source, input ready);
  modport sink (input valid, input sample, input source, output ready);
endinterface

interface mspi_result_if;
  logic                         valid;
  logic                         ready;
  logic [mspi_pkg::DUTY_W-1:0]  duty;
  logic [mspi_pkg::LEVEL_W-1:0] drive_level;

  modport src  (output valid, output duty, output drive_level, input ready);
  modport sink (input valid, input duty, input drive_level, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/motor_speed_pi_controller.sv =====
// Motor speed PI controller: sample scaling, incremental PI step, output clamp.
// Depends on mspi_pkg and the channel interfaces in mspi_channels.sv.
//
//   channel   dir  handshake     payload
//   samples   in   valid/ready   sample, source
//   results   out  valid/ready   duty, drive_level
//   config    in   cfg_we        cfg_index, cfg_data
//
// One item per cycle sustained while results are not stalled. A speed item's result
// is presented once it has passed each step in order: the input register loads at
// acceptance, then the reciprocal estimate, the remainder correction, and the PI step
// into the result register follow. The PI state loop closes through that last step,
// so consecutive items never wait on each other. Setpoint items pass the last stage
// without a result slot. A stalled result holds the last stage; earlier stages keep
// filling until they are full. Reset (synchronous) empties the pipeline, clears
// state, restores the gains.
`default_nettype none

module motor_speed_pi_controller #(
  parameter int SAMPLE_BITS        = mspi_pkg::SAMPLE_BITS_DEF,
  parameter int OUTPUT_LIMIT_VOLTS = mspi_pkg::OUTPUT_LIMIT_VOLTS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  mspi_sample_if.sink                              samples,
  mspi_result_if.src                               results,
  input  wire logic                                cfg_we,
  input  wire logic [mspi_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [mspi_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int SPEED_W = mspi_pkg::SPEED_W;
  localparam int ERROR_W = mspi_pkg::ERROR_W;
  localparam int LEVEL_W = mspi_pkg::LEVEL_W;
  localparam int GAIN_W  = mspi_pkg::GAIN_W;
  localparam int ACC_W   = mspi_pkg::ACC_W;
  localparam int PROD_W  = GAIN_W + 1 + ERROR_W;
  localparam int Y_W     = ACC_W - mspi_pkg::FRAC_SHIFT;

  // speed = floor(s * SPAN / F), F = 2^SAMPLE_BITS - 1
  localparam logic [63:0] FULL_SCALE  = (64'd1 << SAMPLE_BITS) - 64'd1;
  localparam int          REC_SHIFT   = SAMPLE_BITS + SPEED_W;
  localparam logic [63:0] REC_MULT    = (64'd1 << REC_SHIFT) / FULL_SCALE;
  localparam logic [63:0] RECIP_SPAN  = REC_MULT * 64'(mspi_pkg::SPEED_SPAN_Q8);
  localparam int          EST_W       = SAMPLE_BITS + 36;
  localparam int          NUM_W       = SAMPLE_BITS + SPEED_W;

  localparam logic [Y_W-1:0] LIMIT_Q16 = Y_W'(OUTPUT_LIMIT_VOLTS * 65536);

  // configuration registers
  logic [GAIN_W-1:0] gain_current_error;
  logic [GAIN_W-1:0] gain_previous_error;

  // PI state
  logic [SPEED_W-1:0]        target_speed;
  logic signed [ERROR_W-1:0] previous_error;
  logic [LEVEL_W-1:0]        previous_output;

  // pipeline registers
  logic                   v1, src1;
  logic [SAMPLE_BITS-1:0] s1;
  logic                   v2, src2;
  logic [SAMPLE_BITS-1:0] s2;
  logic [SPEED_W-1:0]     q2;
  logic                   v3, src3;
  logic [SPEED_W-1:0]     spd3;
  logic                   ov;
  logic [mspi_pkg::DUTY_W-1:0] duty_r;
  logic [LEVEL_W-1:0]          level_r;

  // flow control
  logic out_free, m1, m2, m3, r1, r2, r3, take;

  assign out_free = !ov || results.ready;
  assign m3 = v3 && ((src3 == mspi_pkg::SRC_SETPOINT) || out_free);
  assign r3 = !v3 || m3;
  assign m2 = v2 && r3;
  assign r2 = !v2 || r3;
  assign m1 = v1 && r2;
  assign r1 = !v1 || r2;
  assign take = samples.valid && r1;
  assign samples.ready = r1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_current_error  <= mspi_pkg::GAIN_CURRENT_RESET;
      gain_previous_error <= mspi_pkg::GAIN_PREVIOUS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mspi_pkg::REG_GAIN_CURRENT:  gain_current_error  <= cfg_data;
        mspi_pkg::REG_GAIN_PREVIOUS: gain_previous_error <= cfg_data;
        default: ;
      endcase
    end
  end

  // estimate speed by reciprocal multiply, low by at most one
  logic [EST_W-1:0]   est;
  logic [SPEED_W-1:0] q_est;
  assign est   = EST_W'(s1) * EST_W'(RECIP_SPAN);
  assign q_est = est[REC_SHIFT +: SPEED_W];

  // correct estimate: bump when remainder reaches full scale
  logic [NUM_W-1:0]   num, q_times_f, rem;
  logic [SPEED_W-1:0] speed_fix;
  assign num       = NUM_W'(s2) * NUM_W'(mspi_pkg::SPEED_SPAN_Q8);
  assign q_times_f = (NUM_W'(q2) << SAMPLE_BITS) - NUM_W'(q2);
  assign rem       = num - q_times_f;
  assign speed_fix = (rem >= NUM_W'(FULL_SCALE)) ? q2 + SPEED_W'(1) : q2;

  // PI step
  logic signed [ERROR_W-1:0] err;
  logic signed [PROD_W-1:0]  p_cur, p_prev;
  logic signed [ACC_W-1:0]   acc;
  logic                      acc_pos;
  logic [Y_W-1:0]            y_raw;
  logic [LEVEL_W-1:0]        y;
  logic [23:0]               y_times10;
  logic [7:0]                duty_raw;
  logic [mspi_pkg::DUTY_W-1:0] duty_next;

  assign err    = $signed({1'b0, target_speed}) - $signed({1'b0, spd3});
  assign p_cur  = $signed({1'b0, gain_current_error}) * err;
  assign p_prev = $signed({1'b0, gain_previous_error}) * previous_error;
  assign acc    = $signed({8'd0, previous_output, 8'd0}) + ACC_W'(p_cur) - ACC_W'(p_prev);
  assign acc_pos = !acc[ACC_W-1] && (acc != '0);
  assign y_raw  = acc[ACC_W-1:mspi_pkg::FRAC_SHIFT];

  // clamp to 0..limit
  always_comb begin
    if (!acc_pos) begin
      y = '0;
    end else if (y_raw > LIMIT_Q16) begin
      y = LEVEL_W'(LIMIT_Q16);
    end else begin
      y = y_raw[LEVEL_W-1:0];
    end
  end

  // duty = floor(10 * y / 2^16), saturated
  assign y_times10 = (24'(y) << 3) + (24'(y) << 1);
  assign duty_raw  = y_times10[23:16];
  assign duty_next = (duty_raw > 8'(mspi_pkg::DUTY_MAX)) ?
                     mspi_pkg::DUTY_W'(mspi_pkg::DUTY_MAX) : duty_raw[mspi_pkg::DUTY_W-1:0];

  // advance valids and PI state
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      ov <= 1'b0;
      target_speed    <= '0;
      previous_error  <= '0;
      previous_output <= '0;
    end else begin
      v1 <= take || (v1 && !m1);
      v2 <= m1 || (v2 && !m2);
      v3 <= m2 || (v3 && !m3);
      ov <= (m3 && (src3 == mspi_pkg::SRC_SPEED)) || (ov && !results.ready);
      if (m3 && (src3 == mspi_pkg::SRC_SETPOINT)) begin
        target_speed <= spd3;
      end
      if (m3 && (src3 == mspi_pkg::SRC_SPEED)) begin
        previous_error  <= err;
        previous_output <= y;
      end
    end
  end

  // load payload registers
  always_ff @(posedge clk) begin
    if (take) begin
      s1   <= samples.sample;
      src1 <= samples.source;
    end
    if (m1) begin
      s2   <= s1;
      src2 <= src1;
      q2   <= q_est;
    end
    if (m2) begin
      src3 <= src2;
      spd3 <= speed_fix;
    end
    if (m3 && (src3 == mspi_pkg::SRC_SPEED)) begin
      duty_r  <= duty_next;
      level_r <= y;
    end
  end

  assign results.valid       = ov;
  assign results.duty        = duty_r;
  assign results.drive_level = level_r;

endmodule

`default_nettype wire
